FILE: design/mbr_pkg.sv
package mbr_pkg;

  // default sizes
  localparam int SMALL_LEN_DEF   = 3;
  localparam int LARGE_LEN_DEF   = 54;
  localparam int SAMPLE_BITS_DEF = 12;

  // result fields
  localparam int OUT_BITS    = 13;
  localparam int OUT_MAX     = 4095;
  localparam int OUT_MIN     = -4096;
  localparam int OUT_TDATA_W = 40;

  // configuration
  localparam int             WEIGHT_BITS = 4;
  localparam logic [3:0]     WEIGHT_RST  = 4'd2;

  // operator slots: opening-closing chain first, then closing-opening
  localparam logic [2:0] OP_OC_FIRST = 3'd0;
  localparam logic [2:0] OP_OC_LAST  = 3'd3;
  localparam logic [2:0] OP_CO_FIRST = 3'd4;
  localparam logic [2:0] OP_CO_LAST  = 3'd7;

  typedef struct packed {
    logic       load;
    logic       small_step;
    logic       large_init;
    logic       large_rd;
    logic       large_wr;
    logic       dly_rd;
    logic       fin_go;
    logic [2:0] op;
  } mbr_cmd_t;

  typedef struct packed {
    logic full;
    logic out_busy;
  } mbr_status_t;

  // erosion, dilation, dilation, erosion / dilation, erosion, erosion, dilation
  function automatic logic op_dilates(input logic [2:0] op);
    return (op == OP_OC_FIRST + 3'd1) || (op == OP_OC_LAST - 3'd1) ||
           (op == OP_CO_FIRST) || (op == OP_CO_LAST);
  endfunction

endpackage

FILE: design/morphological_baseline_removal.sv
// result word follows the input word after eight short-window steps, eight long-window
//   scans and a delay-line read; the next sample is taken only once idle again, set by the
//   sequential scan of the eight large windows through one memory read port
// first 4*(SMALL_LEN-1) + 4*(LARGE_LEN-1) samples give no result (warm-up)
// reset: asynchronous active low, clears control and fill count, weight to 2;
//   window and delay memories are not cleared
module morphological_baseline_removal #(
  parameter int SMALL_LEN   = mbr_pkg::SMALL_LEN_DEF,
  parameter int LARGE_LEN   = mbr_pkg::LARGE_LEN_DEF,
  parameter int SAMPLE_BITS = mbr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample word in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,   // sample, zero pad
  // result word out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [mbr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,   // corrected, baseline,
                                                                 // smoothed, zero pad
  // centre weight write
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mbr_pkg::WEIGHT_BITS-1:0]        cfg_data_i
);
  import mbr_pkg::*;

  mbr_cmd_t                       cmd;
  mbr_status_t                    status;
  logic [$clog2(LARGE_LEN-1)-1:0] idx;
  logic [WEIGHT_BITS-1:0]         weight_q;
  logic [OUT_BITS-1:0]            corrected, baseline, smoothed;

  // weight register, written only while idle
  assign cfg_ready_o = s_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      weight_q <= cfg_data_i;
    end
  end

  // sequencer: eight short-window steps, eight long-window scans, delay update
  mbr_ctrl #(
    .LARGE_LEN (LARGE_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  // windows, min/max unit, delay line and output register
  mbr_datapath #(
    .SMALL_LEN   (SMALL_LEN),
    .LARGE_LEN   (LARGE_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .weight_i    (weight_q),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .corrected_o (corrected),
    .baseline_o  (baseline),
    .smoothed_o  (smoothed)
  );

  // pack lowest field first
  assign m_axis_tdata = {1'b0, smoothed, baseline, corrected};

endmodule

FILE: design/mbr_ctrl.sv
module mbr_ctrl #(
  parameter int LARGE_LEN = mbr_pkg::LARGE_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mbr_pkg::mbr_status_t              status_i,
  output mbr_pkg::mbr_cmd_t                 cmd_o,
  output logic [$clog2(LARGE_LEN-1)-1:0]    idx_o
);
  import mbr_pkg::*;

  localparam int PB = $clog2(LARGE_LEN - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SMALL = 7'b0000010,
    S_LINIT = 7'b0000100,
    S_LRD   = 7'b0001000,
    S_LWR   = 7'b0010000,
    S_DRD   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e         state_q, state_d;
  logic [2:0]     op_q, op_d;
  logic [PB-1:0]  idx_q, idx_d;
  logic           idx_last;

  assign idx_last = (idx_q == PB'(LARGE_LEN - 2));
  assign idx_o    = idx_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = OP_OC_FIRST;
          state_d    = S_SMALL;
        end
      end
      S_SMALL: begin
        cmd_o.small_step = 1'b1;
        if (op_q == OP_CO_LAST) begin
          op_d    = OP_OC_FIRST;
          state_d = S_LINIT;
        end else begin
          op_d = op_q + 3'd1;
        end
      end
      S_LINIT: begin
        cmd_o.large_init = 1'b1;
        idx_d            = '0;
        state_d          = S_LRD;
      end
      S_LRD: begin
        cmd_o.large_rd = 1'b1;
        idx_d          = idx_q + 1'b1;
        if (idx_last) state_d = S_LWR;
      end
      S_LWR: begin
        cmd_o.large_wr = 1'b1;
        if (op_q == OP_CO_LAST) begin
          state_d = S_DRD;
        end else begin
          op_d    = op_q + 3'd1;
          state_d = S_LINIT;
        end
      end
      S_DRD: begin
        cmd_o.dly_rd = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!status_i.full || !status_i.out_busy) begin
          cmd_o.fin_go = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LRD) |-> (idx_q <= PB'(LARGE_LEN - 2)))
    else $error("window scan index out of range");

  a_last_op_to_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LWR && op_q == OP_CO_LAST) |=> (state_q == S_DRD))
    else $error("large stage did not hand over to delay line");

  a_fin_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && status_i.full && status_i.out_busy) |=> (state_q == S_FIN))
    else $error("result dropped while output register busy");

endmodule

FILE: design/mbr_datapath.sv
module mbr_datapath #(
  parameter int SMALL_LEN   = mbr_pkg::SMALL_LEN_DEF,
  parameter int LARGE_LEN   = mbr_pkg::LARGE_LEN_DEF,
  parameter int SAMPLE_BITS = mbr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mbr_pkg::mbr_cmd_t                     cmd_i,
  input  logic [$clog2(LARGE_LEN-1)-1:0]        idx_i,
  input  logic [mbr_pkg::WEIGHT_BITS-1:0]       weight_i,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  output mbr_pkg::mbr_status_t                  status_o,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [mbr_pkg::OUT_BITS-1:0]          corrected_o,
  output logic [mbr_pkg::OUT_BITS-1:0]          baseline_o,
  output logic [mbr_pkg::OUT_BITS-1:0]          smoothed_o
);
  import mbr_pkg::*;

  localparam int DW     = SAMPLE_BITS + 2;
  localparam int SH     = SMALL_LEN - 1;
  localparam int CTR    = SMALL_LEN / 2;
  localparam int HL     = LARGE_LEN - 1;
  localparam int PB     = $clog2(HL);
  localparam int LDEPTH = 8 * (2 ** PB);
  localparam int DL     = 2 * HL;
  localparam int DB     = $clog2(DL);
  localparam int FN     = 4 * SH + 4 * HL;
  localparam int FB     = $clog2(FN + 1);

  typedef logic signed [DW-1:0] val_t;

  function automatic val_t fold(input logic dil, input val_t a, input val_t b);
    if (dil) return (b > a) ? b : a;
    return (b < a) ? b : a;
  endfunction

  // mean truncated toward zero
  function automatic val_t mean2(input val_t a, input val_t b);
    logic signed [DW:0] s;
    s = (DW+1)'(a) + (DW+1)'(b);
    if (s[DW]) s = s + {{DW{1'b0}}, 1'b1};
    return val_t'(s >>> 1);
  endfunction

  function automatic logic [OUT_BITS-1:0] sat13(input logic signed [DW:0] v);
    int t;
    t = int'(v);
    if (t > OUT_MAX) t = OUT_MAX;
    else if (t < OUT_MIN) t = OUT_MIN;
    return t[OUT_BITS-1:0];
  endfunction

  val_t           stin_q, cur_q, oc_q, f1_q, f2_q, acc_q;
  val_t           lrdata_q, drdata_q;
  val_t           sw_q [8][SH];
  val_t           lmem [LDEPTH];
  val_t           dmem [DL];
  logic           rvalid_q;
  logic [PB-1:0]  wptr_q;
  logic [DB-1:0]  dpos_q;
  logic [FB-1:0]  fill_q;
  logic           out_valid_q;
  logic [OUT_BITS-1:0] corr_q, base_q, smooth_q;

  logic                dil, full;
  val_t                op_in, small_res, large_res, wt;
  logic signed [DW:0]  diff;

  assign dil       = op_dilates(cmd_i.op);
  assign op_in     = (cmd_i.op == OP_OC_FIRST || cmd_i.op == OP_CO_FIRST) ? stin_q : cur_q;
  assign wt        = val_t'({1'b0, weight_i});
  assign large_res = fold(dil, acc_q, lrdata_q);
  assign full      = (fill_q == FB'(FN));
  assign diff      = (DW+1)'(drdata_q) - (DW+1)'(f2_q);

  // short window with the weight on its centre tap (mirrored for dilation)
  always_comb begin
    val_t v;
    val_t t;
    small_res = '0;
    for (int p = 0; p < SMALL_LEN; p++) begin
      v = (p < SH) ? sw_q[cmd_i.op][p] : op_in;
      t = (p == (dil ? (SMALL_LEN - 1 - CTR) : CTR)) ? (dil ? v + wt : v - wt) : v;
      small_res = (p == 0) ? t : fold(dil, small_res, t);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) stin_q <= val_t'(signed'(sample_i));
    if (cmd_i.small_step) begin
      for (int p = 0; p < SH - 1; p++) sw_q[cmd_i.op][p] <= sw_q[cmd_i.op][p+1];
      sw_q[cmd_i.op][SH-1] <= op_in;
      cur_q <= small_res;
      if (cmd_i.op == OP_OC_LAST) oc_q <= small_res;
      if (cmd_i.op == OP_CO_LAST) begin
        stin_q <= mean2(oc_q, small_res);
        f1_q   <= mean2(oc_q, small_res);
      end
    end
    if (cmd_i.large_init) acc_q <= op_in;
    if (cmd_i.large_rd && rvalid_q) acc_q <= large_res;
    if (cmd_i.large_wr) begin
      cur_q <= large_res;
      if (cmd_i.op == OP_OC_LAST) oc_q <= large_res;
      if (cmd_i.op == OP_CO_LAST) f2_q <= mean2(oc_q, large_res);
    end
    if (cmd_i.fin_go && full) begin
      corr_q   <= sat13(diff);
      base_q   <= sat13((DW+1)'(f2_q));
      smooth_q <= sat13((DW+1)'(drdata_q));
    end
  end

  // operator windows, circular per slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.large_rd) lrdata_q <= lmem[{cmd_i.op, idx_i}];
    if (cmd_i.large_wr) lmem[{cmd_i.op, wptr_q}] <= op_in;
  end

  // alignment delay line
  always_ff @(posedge clk_i) begin
    if (cmd_i.dly_rd) drdata_q <= dmem[dpos_q];
    if (cmd_i.fin_go) dmem[dpos_q] <= f1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q    <= 1'b0;
      wptr_q      <= '0;
      dpos_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.large_rd;
      if (cmd_i.large_wr && cmd_i.op == OP_CO_LAST) begin
        wptr_q <= (wptr_q == PB'(HL - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (cmd_i.fin_go) begin
        dpos_q <= (dpos_q == DB'(DL - 1)) ? '0 : dpos_q + 1'b1;
        if (!full) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.fin_go && full) out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
    end
  end

  assign status_o.full     = full;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign corrected_o       = corr_q;
  assign baseline_o        = base_q;
  assign smoothed_o        = smooth_q;

  a_last_read_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.large_wr |-> rvalid_q)
    else $error("window write without final read data");

  a_fill_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FB'(FN))
    else $error("fill count past warm-up length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin_go && full) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule
